>>> rtl/pf_pkg.sv
// shared types and codes for the prime factorizer
`timescale 1ns / 1ps

package pf_pkg;

  localparam int unsigned FACTOR_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INPUT_W  = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FACTORS = 2'd1,
    ST_ZERO_INPUT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TWOS,
    S_DIV_START,
    S_DIV_RUN,
    S_DIV_DONE,
    S_FIN_REM,
    S_FIN_LAST
  } state_t;

endpackage

>>> rtl/pf_in_if.sv
// input channel: one number to factorize per item
`timescale 1ns / 1ps

interface pf_in_if;
  logic                          valid;
  logic                          ready;
  logic [pf_pkg::INPUT_W-1:0]    number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

>>> rtl/pf_out_if.sv
// result channel: one prime factor per item (zero for a special status) with status and last marker
`timescale 1ns / 1ps

interface pf_out_if;
  logic                          valid;
  logic                          ready;
  logic [pf_pkg::FACTOR_W-1:0]   factor;
  logic [pf_pkg::STATUS_W-1:0]   status;
  logic                          last;

  modport source (output valid, output factor, output status, output last, input ready);
  modport sink   (input valid, input factor, input status, input last, output ready);
endinterface

>>> rtl/prime_factorizer.sv
// trial division prime factorizer around one shared restoring divider
// steps: strips factors of two one at a time, then runs one restoring division per odd
//   trial divisor; a 32-bit prime takes about 32768 trials
// takes one number at a time; ready only while idle
// each trial also decides the loop bound: the divisor d stops once d exceeds r / d
// reset: synchronous active-low rst_n returns to idle with no result pending
`timescale 1ns / 1ps

module prime_factorizer #(
  parameter int unsigned NUM_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  pf_in_if.sink    in_ch,
  pf_out_if.source out_ch
);

  localparam int unsigned W  = NUM_BITS;
  localparam int unsigned DW = NUM_BITS / 2 + 2;
  localparam int unsigned CW = $clog2(NUM_BITS + 1);

  pf_pkg::state_t state_r, state_nxt;

  logic [W-1:0]   r_r, r_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]   pend_r, pend_nxt;
  logic           pend_v_r, pend_v_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [pf_pkg::FACTOR_W-1:0]  out_factor_r, out_factor_nxt;
  pf_pkg::status_t              out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                 slot_free;
  logic [W+31:0]        num_ext;
  logic [W+31:0]        pend_ext;
  logic [DW:0]          div_sh;
  logic [DW+1:0]        div_diff;
  logic                 div_ge;
  logic [W-1:0]         d_wide;
  logic                 bound_hit;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign num_ext   = {{W{1'b0}}, in_ch.number};
  assign pend_ext  = {32'd0, pend_r};

  // shared unit: one restoring division step per cycle
  assign div_sh   = {rem_r, quo_r[W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, d_r};
  assign div_ge   = !div_diff[DW+1];

  // d above floor(r / d) means d exceeds the integer square root of r
  assign d_wide    = {{(W-DW){1'b0}}, d_r};
  assign bound_hit = d_wide > quo_r;

  assign in_ch.ready   = (state_r == pf_pkg::S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.factor = out_factor_r;
  assign out_ch.status = out_status_r;
  assign out_ch.last   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pf_pkg::S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r          <= r_nxt;
    d_r          <= d_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    pend_r       <= pend_nxt;
    out_factor_r <= out_factor_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    r_nxt          = r_r;
    d_nxt          = d_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_factor_nxt = out_factor_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      pf_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          r_nxt     = num_ext[W-1:0];
          state_nxt = pf_pkg::S_START;
        end
      end

      pf_pkg::S_START: begin
        pend_v_nxt = 1'b0;
        if (r_r > W'(1)) begin
          state_nxt = pf_pkg::S_TWOS;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = '0;
          out_status_nxt = (r_r == '0) ? pf_pkg::ST_ZERO_INPUT : pf_pkg::ST_NO_FACTORS;
          out_last_nxt   = 1'b1;
          state_nxt      = pf_pkg::S_IDLE;
        end
      end

      pf_pkg::S_TWOS: begin
        if (r_r[0]) begin
          d_nxt     = DW'(3);
          state_nxt = pf_pkg::S_DIV_START;
        end else if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_factor_nxt = pend_ext[31:0];
            out_status_nxt = pf_pkg::ST_OK;
            out_last_nxt   = 1'b0;
          end
          pend_nxt   = W'(2);
          pend_v_nxt = 1'b1;
          r_nxt      = r_r >> 1;
        end
      end

      pf_pkg::S_DIV_START: begin
        rem_nxt   = '0;
        quo_nxt   = r_r;
        cnt_nxt   = CW'(W);
        state_nxt = pf_pkg::S_DIV_RUN;
      end

      pf_pkg::S_DIV_RUN: begin
        rem_nxt = div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
        quo_nxt = {quo_r[W-2:0], div_ge};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = pf_pkg::S_DIV_DONE;
        end
      end

      pf_pkg::S_DIV_DONE: begin
        if (bound_hit) begin
          state_nxt = pf_pkg::S_FIN_REM;
        end else if (rem_r != '0) begin
          d_nxt     = d_r + DW'(2);
          state_nxt = pf_pkg::S_DIV_START;
        end else if (!pend_v_r || slot_free) begin
          // divisor found: hand the previous factor on and keep d for a repeat
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_factor_nxt = pend_ext[31:0];
            out_status_nxt = pf_pkg::ST_OK;
            out_last_nxt   = 1'b0;
          end
          pend_nxt   = d_wide;
          pend_v_nxt = 1'b1;
          r_nxt      = quo_r;
          state_nxt  = pf_pkg::S_DIV_START;
        end
      end

      pf_pkg::S_FIN_REM: begin
        if (r_r <= W'(1)) begin
          state_nxt = pf_pkg::S_FIN_LAST;
        end else if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_factor_nxt = pend_ext[31:0];
            out_status_nxt = pf_pkg::ST_OK;
            out_last_nxt   = 1'b0;
          end
          pend_nxt   = r_r;
          pend_v_nxt = 1'b1;
          state_nxt  = pf_pkg::S_FIN_LAST;
        end
      end

      pf_pkg::S_FIN_LAST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = pend_ext[31:0];
          out_status_nxt = pf_pkg::ST_OK;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = pf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pf_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("block still ready after taking an item");

  a_special_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != pf_pkg::ST_OK) |-> (out_ch.last && out_ch.factor == '0))
    else $error("special status result not a lone zero item");

  a_ok_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == pf_pkg::ST_OK) |-> (out_ch.factor >= 32'd2))
    else $error("factor below two");

  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pf_pkg::S_DIV_RUN) |-> (d_r[0] && d_r >= DW'(3)))
    else $error("trial divisor not odd and at least three");

  a_last_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pf_pkg::S_FIN_LAST) |-> pend_v_r)
    else $error("final result with no factor held");
`endif

endmodule

>>> test/tb_top.sv
// self-checking testbench for prime_factorizer: directed and random numbers, factor, status and last check
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_BITS    = 32;
  localparam int          MAX_FACTORS = 32;
  localparam int          LONG_HOLD   = 2000;
  localparam int          DRAIN_CYCLES = 100;
  // slowest item here is a 22-bit noise value at about 1024 trials; the limit is set
  // several times above what all 102 items need even with every stall
  localparam longint      LIMIT_CYCLES = 20_000_000;

  typedef struct packed {
    logic [pf_pkg::FACTOR_W-1:0] factor;
    pf_pkg::status_t             status;
    logic                        last;
  } factor_rec_t;

  logic clk;
  logic rst_n;

  pf_in_if  in_ch ();
  pf_out_if out_ch ();

  prime_factorizer #(
    .NUM_BITS(NUM_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  factor_rec_t pending_factors[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  int          burst_left  = 0;
  int          hold_reqs   = 0;
  int          hold_served = 0;
  int          hold_left   = 0;
  int          rx_mode     = 0;
  int          rx_mode_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // floor square root, built one bit at a time from the top
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  function automatic void predict_factors(input logic [pf_pkg::INPUT_W-1:0] number);
    logic [63:0] keep;
    logic [63:0] rest;
    logic [63:0] divisor;
    logic [63:0] root;
    logic [63:0] found[$];
    keep = (NUM_BITS >= 64) ? '1 : ((64'd1 << NUM_BITS) - 64'd1);
    rest = 64'(number) & keep;
    if (rest == 0) begin
      pending_factors.push_back('{factor: '0, status: pf_pkg::ST_ZERO_INPUT, last: 1'b1});
      return;
    end
    if (rest == 1) begin
      pending_factors.push_back('{factor: '0, status: pf_pkg::ST_NO_FACTORS, last: 1'b1});
      return;
    end
    while (found.size() < MAX_FACTORS && rest[0] == 1'b0) begin
      found.push_back(64'd2);
      rest = rest >> 1;
    end
    root    = int_sqrt(rest);
    divisor = 64'd3;
    while (found.size() < MAX_FACTORS && divisor <= root) begin
      if (rest % divisor == 0) begin
        found.push_back(divisor);
        rest = rest / divisor;
        root = int_sqrt(rest);
      end else begin
        divisor = divisor + 2;
      end
    end
    if (found.size() < MAX_FACTORS && rest > 1) found.push_back(rest);
    foreach (found[k]) begin
      pending_factors.push_back('{factor: found[k][pf_pkg::FACTOR_W-1:0],
                                  status: pf_pkg::ST_OK,
                                  last: (k == found.size() - 1)});
    end
  endfunction

  // small-prime-rich number with one moderate cofactor, so trial division stays short
  function automatic logic [pf_pkg::INPUT_W-1:0] smooth_number();
    logic [63:0] x;
    logic [63:0] p;
    int          sel;
    int          n;
    sel = $urandom_range(0, 9);
    if (sel < 5) x = 64'($urandom_range(2, 4095));
    else if (sel < 8) x = 64'($urandom_range(2, 65535));
    else x = 64'($urandom_range(2, 1 << 20));
    n = $urandom_range(0, 14);
    repeat (n) begin
      p = 64'($urandom_range(2, 97));
      if (x * p <= 64'hFFFF_FFFF) x = x * p;
    end
    return x[pf_pkg::INPUT_W-1:0];
  endfunction

  // offer one number, honouring the burst and gap pattern
  task automatic send_number(input logic [pf_pkg::INPUT_W-1:0] number);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    in_ch.valid  <= 1'b1;
    in_ch.number <= number;
    do @(posedge clk); while (!in_ch.ready);
    predict_factors(number);
    burst_left--;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_left   = LONG_HOLD;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 128);
      end else begin
        rx_mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    factor_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_factors.size() == 0) begin
        report_mismatch($sformatf("unexpected item: factor %0d status %0d last %0b",
                                  out_ch.factor, out_ch.status, out_ch.last));
      end else begin
        want = pending_factors.pop_front();
        if (out_ch.factor !== want.factor)
          report_mismatch($sformatf("factor %0d, expected %0d", out_ch.factor, want.factor));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b (factor %0d)",
                                    out_ch.last, want.last, want.factor));
      end
    end
  end

  task automatic test_special_inputs();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd2);
    send_number(32'd3);
    send_number(32'd4);
  endtask

  task automatic test_bit_extremes();
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'hAAAA_AAAA);
    send_number(32'h5555_5555);
  endtask

  task automatic test_powers_and_squares();
    send_number(32'd9);
    send_number(32'd15);
    send_number(32'd25);
    send_number(32'd49);
    send_number(32'd1018081);        // 1009 squared
    send_number(32'd3486784401);     // 3 to the 20th
    send_number(32'd65521);          // largest 16-bit prime
    send_number(32'd65537);
    send_number(32'd65521 << 15);
    send_number(32'd223092870);      // primorial up to 23
  endtask

  // receiver holds off long while numbers keep coming, so the block backs up
  task automatic test_backpressure();
    hold_reqs++;
    burst_left = 10;
    for (int k = 0; k < 8; k++) send_number(smooth_number());
  endtask

  task automatic test_random_numbers();
    int sel;
    logic [pf_pkg::INPUT_W-1:0] n;
    for (int k = 0; k < 75; k++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) n = $urandom_range(0, 1);
      else if (sel < 4) n = $urandom() >> $urandom_range(10, 31);
      else n = smooth_number();
      send_number(n);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.number = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_inputs();
    test_bit_extremes();
    test_powers_and_squares();
    test_backpressure();
    test_random_numbers();
    in_ch.valid <= 1'b0;

    while (pending_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pf_pkg.sv
rtl/pf_in_if.sv
rtl/pf_out_if.sv
rtl/prime_factorizer.sv
test/tb_top.sv
